// File: src/spq_pkg.sv
package spq_pkg;
  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int UrgW = 8;
  localparam int FieldW = 31;

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqRemove = 1'b1;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [UrgW-1:0]   urg;
    logic [FieldW-1:0] nid;
    logic [FieldW-1:0] usr;
    logic [FieldW-1:0] dat;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic ins;
    logic rem;
    logic fin;
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } spq_sts_t;
endpackage

// File: src/spq_ctrl.sv
module spq_ctrl import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     req_type_i,
  input  spq_sts_t sts_i,
  output spq_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o,
  output logic [1:0] status_o
);
  localparam logic [0:0] SIdle = 1'b0;
  localparam logic [0:0] SExec = 1'b1;

  logic [0:0] state_q, state_d;
  logic       op_q;
  logic [1:0] status_q, status_d;
  logic       acc;

  assign acc = start_i && (state_q == SIdle);

  // next state and result status
  always_comb begin
    state_d = state_q;
    status_d = status_q;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = SExec;
          if (req_type_i == ReqInsert) status_d = sts_i.full ? StFull : StOk;
          else status_d = sts_i.empty ? StEmpty : StOk;
        end
      end
      SExec: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      status_q <= StOk;
      op_q <= ReqInsert;
    end else begin
      state_q <= state_d;
      status_q <= status_d;
      if (acc) op_q <= req_type_i;
    end
  end

  assign cmd_o.load = acc;
  assign cmd_o.ins = (state_q == SExec) && (op_q == ReqInsert) && (status_q == StOk);
  assign cmd_o.rem = (state_q == SExec) && (op_q == ReqRemove) && (status_q == StOk);
  assign cmd_o.fin = (state_q == SExec);
  assign busy_o = (state_q != SIdle);
  assign done_o = (state_q == SExec);
  assign status_o = status_q;
endmodule

// File: src/spq_dpath.sv
module spq_dpath import spq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_cmd_t          cmd_i,
  input  entry_t            in_i,
  output spq_sts_t          sts_o,
  output entry_t            taken_o,
  output entry_t            head_o,
  output logic [CntW-1:0]   count_o
);
  // sorted cell chain, slot 0 is the head
  entry_t          cell_q [Capacity];
  logic [CntW-1:0] cnt_q;
  entry_t          new_q;
  entry_t          taken_q;
  logic [Capacity-1:0] ge;

  // each cell compares itself with the pending entry
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      ge[i] = (CntW'(i) < cnt_q) && (cell_q[i].urg >= new_q.urg);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) new_q <= in_i;
    if (cmd_i.ins) begin
      // cells keep, shift down, or take the new entry
      for (int i = 0; i < Capacity; i++) begin
        if (!ge[i]) begin
          if (i == 0 || ge[(i == 0) ? 0 : i-1]) cell_q[i] <= new_q;
          else cell_q[i] <= cell_q[(i == 0) ? 0 : i-1];
        end
      end
    end else if (cmd_i.rem) begin
      for (int i = 0; i < Capacity - 1; i++) cell_q[i] <= cell_q[i+1];
    end
    if (cmd_i.fin) taken_q <= cmd_i.rem ? cell_q[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.ins) cnt_q <= cnt_q + 1'b1;
    else if (cmd_i.rem) cnt_q <= cnt_q - 1'b1;
  end

  assign sts_o.full = (cnt_q == CntW'(Capacity));
  assign sts_o.empty = (cnt_q == '0);
  assign taken_o = taken_q;
  assign head_o = (cnt_q == '0) ? '0 : cell_q[0];
  assign count_o = cnt_q;
endmodule

// File: src/stable_priority_queue.sv
// Stable priority queue of notification records, 64 entries.
// Command channel: start with req_type_i (insert or remove) and the
// record fields is taken when busy is low. Insert places the record
// behind every stored entry of equal or higher urgency; remove takes the head.
// Every request gives one result: done_o is high for exactly one cycle,
// registered after the execute state, carrying status, the removed record
// (zero if none), the head after the operation, the count and an empty flag.
// Requests overlap in part: in the execute state busy is high and the
// whole cell chain shifts in parallel, each cell comparing its urgency with
// the new one; the result is then shown while the next request can be taken.
// Result fields are valid only in the done_o cycle and may change right
// after it; the receiver cannot stall, so each result is taken then.
// Reset clears the count, leaving an empty queue; it is ready at once.
// Remove on empty gives status 1, insert when full gives status 2 and
// drops the record.
module stable_priority_queue import spq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              req_type_i,
  input  logic [FieldW-1:0] note_id_i,
  input  logic [FieldW-1:0] target_user_i,
  input  logic [FieldW-1:0] date_stamp_i,
  input  logic [UrgW-1:0]   urgency_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [FieldW-1:0] taken_note_id_o,
  output logic [FieldW-1:0] taken_user_o,
  output logic [FieldW-1:0] taken_date_o,
  output logic [UrgW-1:0]   taken_urgency_o,
  output logic [FieldW-1:0] head_note_id_o,
  output logic [FieldW-1:0] head_user_o,
  output logic [FieldW-1:0] head_date_o,
  output logic [UrgW-1:0]   head_urgency_o,
  output logic [CntW-1:0]   entry_count_o,
  output logic              is_empty_o
);
  spq_cmd_t cmd;
  spq_sts_t sts;
  entry_t   in_e, taken, head;
  logic     done_c;

  assign in_e = '{urg: urgency_i, nid: note_id_i, usr: target_user_i, dat: date_stamp_i};

  spq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .req_type_i, .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .done_o(done_c), .status_o
  );

  spq_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i(in_e), .sts_o(sts),
    .taken_o(taken), .head_o(head), .count_o(entry_count_o)
  );

  // result strobe: registered, in the cycle after the execute cycle
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= done_c;
  end
  assign done_o = done_q;

  assign taken_note_id_o = taken.nid;
  assign taken_user_o = taken.usr;
  assign taken_date_o = taken.dat;
  assign taken_urgency_o = taken.urg;
  assign head_note_id_o = head.nid;
  assign head_user_o = head.usr;
  assign head_date_o = head.dat;
  assign head_urgency_o = head.urg;
  assign is_empty_o = (entry_count_o == '0);
endmodule

// File: src/spq_checker.sv
module spq_checker import spq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic [1:0] status_o,
  input logic [CntW-1:0] entry_count_o,
  input logic is_empty_o
);
  // accepted request yields a result on done_o
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 done_o) else $error("missing result");
  a_emp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (entry_count_o == '0))) else $error("empty flag");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= CntW'(Capacity)) else $error("count overflow");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == StEmpty |-> is_empty_o) else $error("bad empty status");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == StFull |-> entry_count_o == CntW'(Capacity))
    else $error("bad full status");
endmodule

bind stable_priority_queue spq_checker u_chk (.*);
